// ----- src/bld_pkg.sv -----
// ----------------------------------------------------------------------------
// bld_pkg
// Shared types and codes for the bounded list deque engine: request and
// response payloads, operation and status codes, controller states and the
// command group that runs the datapath.
// ----------------------------------------------------------------------------
package bld_pkg;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_READ_FRONT = 3'd3,
		OP_READ_AT    = 3'd4,
		OP_KEEP_FIRST = 3'd5,
		OP_DROP_FIRST = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] value_in;
		logic [4:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [4:0]         list_length;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_EMIT = 2'd2
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic load_out;
	} cmd_t;

endpackage

// ----- src/bld_ctrl.sv -----
// ----------------------------------------------------------------------------
// bld_ctrl
// Sequencer for one list operation at a time: capture the item, execute it
// against the ring store, then hand the result to the output register.
// ----------------------------------------------------------------------------
module bld_ctrl import bld_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				// hold the result until the output register frees up
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/bld_dp.sv -----
// ----------------------------------------------------------------------------
// bld_dp
// Datapath: request register, ring store with front pointer and count,
// ring index arithmetic, status decode and the output register.
// ----------------------------------------------------------------------------
module bld_dp import bld_pkg::*; #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t in_data,
	input  cmd_t cmd,
	output rsp_t out_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = PW + 1;
	localparam int NW = (CW > 5) ? CW : 5;
	localparam int XW = (DATA_W > 32) ? DATA_W : 32;

	// base + off stays below twice the depth, so one subtract wraps it
	function automatic logic [PW-1:0] ring_slot(input logic [PW-1:0] base,
	                                            input logic [CW-1:0] off);
		logic [AW-1:0] sum;
		sum = AW'(base) + AW'(off);
		if (sum >= AW'(DEPTH)) begin
			sum = sum - AW'(DEPTH);
		end
		return sum[PW-1:0];
	endfunction

	req_t              req_q;
	logic [PW-1:0]     front_q, front_d;
	logic [CW-1:0]     count_q, count_d;
	status_t           sts_q, sts_d;
	logic              rd_used_q;
	logic              we, re;
	logic [PW-1:0]     waddr, raddr;
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q, wdata;
	logic              full, empty;
	logic [NW-1:0]     n_w, cnt_w;
	logic [CW-1:0]     n_c, drop_c;
	logic [XW-1:0]     val_x, rd_x;
	rsp_t              out_q;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign n_w    = NW'(req_q.position);
	assign cnt_w  = NW'(count_q);
	assign n_c    = n_w[CW-1:0];
	assign drop_c = (n_w < cnt_w) ? n_c : count_q;
	assign val_x  = XW'($unsigned(req_q.value_in));
	assign wdata  = val_x[DATA_W-1:0];
	assign rd_x   = XW'(rdata_q);

	always_comb begin
		front_d = front_q;
		count_d = count_q;
		sts_d   = ST_OK;
		we      = 1'b0;
		re      = 1'b0;
		waddr   = front_q;
		raddr   = front_q;
		case (op_t'(req_q.req_type))
			OP_PUSH_FRONT: begin
				if (full) begin
					sts_d = ST_FULL;
				end else begin
					front_d = (front_q == '0) ? PW'(DEPTH - 1) : front_q - 1'b1;
					waddr   = front_d;
					we      = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					sts_d = ST_FULL;
				end else begin
					waddr   = ring_slot(front_q, count_q);
					we      = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (!empty) begin
					front_d = ring_slot(front_q, CW'(1));
					count_d = count_q - 1'b1;
				end
			end
			OP_READ_FRONT: begin
				if (empty) begin
					sts_d = ST_EMPTY;
				end else begin
					re = 1'b1;
				end
			end
			OP_READ_AT: begin
				if (n_w >= cnt_w) begin
					sts_d = ST_RANGE;
				end else begin
					raddr = ring_slot(front_q, n_c);
					re    = 1'b1;
				end
			end
			OP_KEEP_FIRST: begin
				if (n_w != '0 && n_w < cnt_w) begin
					count_d = n_c;
				end
			end
			OP_DROP_FIRST: begin
				front_d = ring_slot(front_q, drop_c);
				count_d = count_q - drop_c;
			end
			OP_CLEAR: begin
				front_d = '0;
				count_d = '0;
			end
			default: begin
				front_d = front_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= in_data;
		end
		if (cmd.exec) begin
			sts_q     <= sts_d;
			rd_used_q <= re;
		end
		if (cmd.load_out) begin
			out_q.read_value  <= rd_used_q ? rd_x[31:0] : '0;
			out_q.list_length <= cnt_w[4:0];
			out_q.status      <= sts_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			if (re) begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign out_data = out_q;

endmodule

// ----- src/bounded_list_deque_engine.sv -----
// ----------------------------------------------------------------------------
// bounded_list_deque_engine
// Bounded double-ended list of up to DEPTH elements kept in a ring store.
// ----------------------------------------------------------------------------
// Each accepted item is one list operation (push front/back, pop front, read
// front, read at, keep first n, drop first n, clear) and produces exactly one
// result with the read value, the length after the operation and a status.
// An item passes from acceptance to the result in order: capture it, update
// the pointers and access the single-port ring memory (whose read data is
// registered), then load the output register. A new item is taken only once
// the previous one has loaded its result; a stalled output holds the engine
// once its result register is full. The ring store has no reset; only entries
// written by a push are ever read.
module bounded_list_deque_engine import bld_pkg::*; #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);

	cmd_t cmd;

	bld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	bld_dp #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.out_data (out_data)
	);

endmodule

// ----- src/bld_chk.sv -----
// ----------------------------------------------------------------------------
// bld_chk
// Port-level checks for the bounded list deque engine, bound to the top.
// ----------------------------------------------------------------------------
module bld_chk import bld_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input req_t in_data,
	input logic out_valid,
	input logic out_ready,
	input rsp_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one item in flight: no acceptance right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in flight");

	// empty read reports an empty list
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_EMPTY |-> out_data.list_length == '0)
		else $error("empty read with nonzero length");

	// errors return zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.read_value == '0)
		else $error("nonzero read value on error status");

	// a waiting item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("item changed while waiting");

endmodule

bind bounded_list_deque_engine bld_chk u_bld_chk (.*);

// ----- tb/bounded_list_deque_engine_tb.sv -----
// ----------------------------------------------------------------------------
// bounded_list_deque_engine_tb
// Self-checking bench for the ring-store deque. A short table of directed
// list operations covers the empty and full edges, every opcode and the
// error codes. A long random phase follows that swings the list between
// empty and full. Each accepted item is run through a local deque model and
// every response is compared field by field in order.
// ----------------------------------------------------------------------------
module bounded_list_deque_engine_tb;
	import bld_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int RANDOM_OPS = 1700;
	localparam int CALM_FROM  = 1450;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_data;
	logic out_valid;
	logic out_ready;
	rsp_t out_data;

	bounded_list_deque_engine #(
		.DEPTH (LIST_DEPTH),
		.DATA_W(32)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// local copy of the list
	logic [31:0] ring_mem [LIST_DEPTH];
	logic [3:0]  head_idx;
	logic [4:0]  elem_cnt;

	rsp_t pending_rsp[$];

	// directed table
	typedef struct {
		op_t         op;
		logic [31:0] val;
		logic [4:0]  pos;
		bit          typed;
		rsp_t        want;
	} dir_row_t;
	dir_row_t dir_rows[$];

	int err_cnt      = 0;
	int checked_cnt  = 0;
	int sent_cnt     = 0;
	int full_hits    = 0;
	int bad_reads    = 0;
	int peak_len     = 0;
	int op_hits [8];
	bit idle_en      = 1'b0;
	bit grow_mode    = 1'b1;
	int stall_left   = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		err_cnt++;
		$display("MISMATCH %s: got 0x%08h, want 0x%08h (result %0d)", what, got, want,
			checked_cnt);
	endtask

	function automatic rsp_t apply_list_op(input req_t item);
		rsp_t       res;
		logic [3:0] slot;
		logic [4:0] cut;
		res.read_value = '0;
		res.status     = ST_OK;
		case (op_t'(item.req_type))
			OP_PUSH_FRONT: begin
				if (elem_cnt == LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					head_idx = head_idx - 4'd1;
					ring_mem[head_idx] = item.value_in;
					elem_cnt = elem_cnt + 5'd1;
				end
			end
			OP_PUSH_BACK: begin
				if (elem_cnt == LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					slot = head_idx + elem_cnt[3:0];
					ring_mem[slot] = item.value_in;
					elem_cnt = elem_cnt + 5'd1;
				end
			end
			OP_POP_FRONT: begin
				if (elem_cnt != 0) begin
					head_idx = head_idx + 4'd1;
					elem_cnt = elem_cnt - 5'd1;
				end
			end
			OP_READ_FRONT: begin
				if (elem_cnt == 0)
					res.status = ST_EMPTY;
				else
					res.read_value = ring_mem[head_idx];
			end
			OP_READ_AT: begin
				if (item.position >= elem_cnt) begin
					res.status = ST_RANGE;
				end else begin
					slot = head_idx + item.position[3:0];
					res.read_value = ring_mem[slot];
				end
			end
			OP_KEEP_FIRST: begin
				if (item.position != 0 && item.position < elem_cnt)
					elem_cnt = item.position;
			end
			OP_DROP_FIRST: begin
				cut = (item.position < elem_cnt) ? item.position : elem_cnt;
				head_idx = head_idx + cut[3:0];
				elem_cnt = elem_cnt - cut;
			end
			default: begin
				elem_cnt = '0;
				head_idx = '0;
			end
		endcase
		res.list_length = elem_cnt;
		return res;
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 3))
				0: v = 32'h0000_0000;
				1: v = 32'hFFFF_FFFF;
				2: v = 32'h7FFF_FFFF;
				default: v = 32'h8000_0000;
			endcase
		end
		return v;
	endfunction

	function automatic req_t make_random_op();
		req_t        item;
		int unsigned r;
		int unsigned push_pct;
		int unsigned t_pop, t_rf, t_ra, t_keep, t_drop;
		// swing between filling and draining so both edges are hit often
		if (elem_cnt == LIST_DEPTH)
			grow_mode = 1'b0;
		else if (elem_cnt == 0)
			grow_mode = 1'b1;
		else if ($urandom_range(0, 59) == 0)
			grow_mode = !grow_mode;
		if (grow_mode) begin
			push_pct = 60;
			t_pop = 20; t_rf = 40; t_ra = 75; t_keep = 85; t_drop = 97;
		end else begin
			push_pct = 30;
			t_pop = 30; t_rf = 42; t_ra = 60; t_keep = 75; t_drop = 92;
		end
		item.value_in = pick_value();
		item.position = 5'($urandom_range(0, LIST_DEPTH));
		r = $urandom_range(0, 99);
		if (r < push_pct) begin
			item.req_type = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		end else begin
			r = $urandom_range(0, 99);
			if (r < t_pop)
				item.req_type = OP_POP_FRONT;
			else if (r < t_rf)
				item.req_type = OP_READ_FRONT;
			else if (r < t_ra)
				item.req_type = OP_READ_AT;
			else if (r < t_keep)
				item.req_type = OP_KEEP_FIRST;
			else if (r < t_drop)
				item.req_type = OP_DROP_FIRST;
			else
				item.req_type = OP_CLEAR;
			// aim mostly around the current length so boundaries get hit
			if ($urandom_range(0, 9) < 7)
				item.position = 5'($urandom_range(0, elem_cnt));
		end
		return item;
	endfunction

	task automatic add_row(input op_t op, input logic [31:0] val, input logic [4:0] pos,
		input bit typed, input logic [31:0] rd, input logic [4:0] len, input status_t st);
		dir_row_t row;
		row.op   = op;
		row.val  = val;
		row.pos  = pos;
		row.typed = typed;
		row.want.read_value = rd;
		row.want.list_length = len;
		row.want.status = st;
		dir_rows.push_back(row);
	endtask

	task automatic send_item(input req_t item, input bit typed, input rsp_t want);
		rsp_t pred;
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = apply_list_op(item);
		pending_rsp.push_back(typed ? want : pred);
		sent_cnt++;
		op_hits[item.req_type]++;
		if (pred.status == ST_FULL)
			full_hits++;
		if (pred.status == ST_EMPTY || pred.status == ST_RANGE)
			bad_reads++;
		if (int'(pred.list_length) > peak_len)
			peak_len = pred.list_length;
		if (idle_en && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
	endtask

	task automatic check_rsp(input rsp_t got);
		rsp_t want;
		if (pending_rsp.size() == 0) begin
			report_mismatch("unexpected result", got.read_value, '0);
			return;
		end
		want = pending_rsp.pop_front();
		if (got.read_value !== want.read_value)
			report_mismatch("read_value", got.read_value, want.read_value);
		if (got.list_length !== want.list_length)
			report_mismatch("list_length", 32'(got.list_length), 32'(want.list_length));
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		checked_cnt++;
	endtask

	// response side: random stall bursts, none while idling is off
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				check_rsp(out_data);
			if (stall_left > 0)
				stall_left--;
			else if (idle_en && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 17);
			out_ready <= arst_n && (stall_left == 0);
		end
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d items sent, %0d results checked", sent_cnt, checked_cnt);
		$display("simulation failed");
		$finish;
	end

	initial begin
		req_t item;
		rsp_t none;
		none = '0;
		head_idx = '0;
		elem_cnt = '0;
		foreach (op_hits[k])
			op_hits[k] = 0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;

		add_row(OP_READ_FRONT, 32'h0, 5'd0, 1, 32'h0, 5'd0, ST_EMPTY);
		add_row(OP_READ_AT, 32'hFFFF_FFFF, 5'd16, 1, 32'h0, 5'd0, ST_RANGE);
		add_row(OP_POP_FRONT, 32'h0, 5'd0, 1, 32'h0, 5'd0, ST_OK);
		add_row(OP_DROP_FIRST, 32'h0, 5'd16, 1, 32'h0, 5'd0, ST_OK);
		add_row(OP_PUSH_BACK, 32'h7FFF_FFFF, 5'd31 & 5'd16, 1, 32'h0, 5'd1, ST_OK);
		add_row(OP_PUSH_FRONT, 32'h8000_0000, 5'd0, 1, 32'h0, 5'd2, ST_OK);
		add_row(OP_READ_FRONT, 32'h0, 5'd0, 1, 32'h8000_0000, 5'd2, ST_OK);
		add_row(OP_READ_AT, 32'h0, 5'd1, 1, 32'h7FFF_FFFF, 5'd2, ST_OK);
		// fill to the top from both ends
		for (int i = 0; i < LIST_DEPTH - 2; i++)
			add_row(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom, 5'(i), 0, 32'h0, 5'd0,
				ST_OK);
		add_row(OP_PUSH_FRONT, 32'hFFFF_FFFF, 5'd0, 1, 32'h0, 5'd16, ST_FULL);
		add_row(OP_PUSH_BACK, 32'h0, 5'd16, 1, 32'h0, 5'd16, ST_FULL);
		add_row(OP_READ_AT, 32'h0, 5'd16, 1, 32'h0, 5'd16, ST_RANGE);
		add_row(OP_READ_AT, 32'h0, 5'd15, 0, 32'h0, 5'd0, ST_OK);
		add_row(OP_KEEP_FIRST, 32'h0, 5'd16, 1, 32'h0, 5'd16, ST_OK);
		add_row(OP_KEEP_FIRST, 32'h0, 5'd0, 1, 32'h0, 5'd16, ST_OK);
		add_row(OP_DROP_FIRST, 32'h0, 5'd1, 1, 32'h0, 5'd15, ST_OK);
		add_row(OP_KEEP_FIRST, 32'h0, 5'd3, 1, 32'h0, 5'd3, ST_OK);
		add_row(OP_READ_AT, 32'h0, 5'd2, 0, 32'h0, 5'd0, ST_OK);
		add_row(OP_CLEAR, 32'h0, 5'd0, 1, 32'h0, 5'd0, ST_OK);
		add_row(OP_PUSH_FRONT, 32'h1234_5678, 5'd0, 1, 32'h0, 5'd1, ST_OK);
		add_row(OP_READ_FRONT, 32'h0, 5'd0, 1, 32'h1234_5678, 5'd1, ST_OK);
		add_row(OP_DROP_FIRST, 32'h0, 5'd5, 1, 32'h0, 5'd0, ST_OK);

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		foreach (dir_rows[i]) begin
			item.req_type = dir_rows[i].op;
			item.value_in = dir_rows[i].val;
			item.position = dir_rows[i].pos;
			send_item(item, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int i = 0; i < RANDOM_OPS; i++) begin
			// idle in long stretches, then leave a quiet stretch at the end
			idle_en = (i < CALM_FROM) && ((i / 150) % 3 != 2);
			if (i == 700) begin
				// hold off until the engine has drained completely
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_rsp.size() != 0)
					@(posedge clk);
			end
			send_item(make_random_op(), 0, none);
		end

		idle_en = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (12)
			@(posedge clk);

		$display("ran %0d list operations, %0d responses checked, peak length %0d",
			sent_cnt, checked_cnt, peak_len);
		$display("ops pf/pb/pop/rf/ra/keep/drop/clr %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d,",
			op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4], op_hits[5],
			op_hits[6], op_hits[7]);
		$display("%0d full pushes, %0d bad reads", full_hits, bad_reads);
		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
